@@ rtl/ipv4ep_pkg.sv @@
// Package for the IPv4 endpoint text parser: word types, parser state and
// character constants. No dependencies; used by every module in rtl.
package ipv4ep_pkg;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [2:0] LAST_OCTET   = 3'd3;
   localparam logic [2:0] OCTET_DIGITS = 3'd3;
   localparam logic [2:0] PORT_DIGITS  = 3'd5;
   localparam logic [2:0] OCTET_COUNT  = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  octet_0;
      logic [7:0]  octet_1;
      logic [7:0]  octet_2;
      logic [7:0]  octet_3;
      logic [15:0] port_number;
   } rsp_word_type;

   typedef struct packed {
      logic            in_port_phase;
      logic            failed;
      logic [2:0]      octet_index;
      logic [2:0]      digit_count;
      logic [9:0]      octet_value;
      logic [3:0][7:0] captured_octets;
      logic [16:0]     port_value;
   } parse_state_type;

endpackage

@@ rtl/ipv4ep_step.sv @@
// Next-state and verdict logic for one word of the endpoint parser.
// Depends on ipv4ep_pkg; instantiated by ipv4_endpoint_text_parser.
module ipv4ep_step import ipv4ep_pkg::*; (
   input  req_word_type    word,
   input  parse_state_type state_cur,
   output parse_state_type state_nxt,
   output rsp_word_type    result
);

   logic        is_digit;
   logic [3:0]  digit;
   logic        close_ok;
   logic [9:0]  octet_acc;
   logic [16:0] port_acc;

   assign is_digit  = (word.character >= CHAR_ZERO) && (word.character <= CHAR_NINE);
   assign digit     = 4'(word.character - CHAR_ZERO);
   assign close_ok  = (state_cur.digit_count != 3'd0) && (state_cur.octet_value[9:8] == 2'b00);
   assign octet_acc = 10'({state_cur.octet_value, 3'b000} + {state_cur.octet_value, 1'b0}
                          + 13'(digit));
   assign port_acc  = 17'({state_cur.port_value, 3'b000} + {state_cur.port_value, 1'b0}
                          + 20'(digit));

   always_comb begin
      state_nxt = state_cur;
      result.ok = !state_cur.failed && state_cur.in_port_phase && !state_cur.port_value[16];
      result.octet_0     = result.ok ? state_cur.captured_octets[0] : 8'd0;
      result.octet_1     = result.ok ? state_cur.captured_octets[1] : 8'd0;
      result.octet_2     = result.ok ? state_cur.captured_octets[2] : 8'd0;
      result.octet_3     = result.ok ? state_cur.captured_octets[3] : 8'd0;
      result.port_number = result.ok ? state_cur.port_value[15:0] : 16'd0;
      if (word.kind == KIND_END) begin
         state_nxt = '0;
      end else if (!state_cur.failed) begin
         if (word.character == CHAR_COLON) begin
            if (state_cur.in_port_phase || state_cur.octet_index != LAST_OCTET || !close_ok) begin
               state_nxt.failed = 1'b1;
            end else begin
               state_nxt.captured_octets[state_cur.octet_index[1:0]] =
                  state_cur.octet_value[7:0];
               state_nxt.octet_index   = state_cur.octet_index + 3'd1;
               state_nxt.digit_count   = 3'd0;
               state_nxt.octet_value   = 10'd0;
               state_nxt.in_port_phase = 1'b1;
            end
         end else if (!state_cur.in_port_phase) begin
            if (word.character == CHAR_DOT) begin
               if (state_cur.octet_index >= LAST_OCTET || !close_ok) begin
                  state_nxt.failed = 1'b1;
               end else begin
                  state_nxt.captured_octets[state_cur.octet_index[1:0]] =
                     state_cur.octet_value[7:0];
                  state_nxt.octet_index = state_cur.octet_index + 3'd1;
                  state_nxt.digit_count = 3'd0;
                  state_nxt.octet_value = 10'd0;
               end
            end else if (is_digit && state_cur.digit_count < OCTET_DIGITS) begin
               state_nxt.octet_value = octet_acc;
               state_nxt.digit_count = state_cur.digit_count + 3'd1;
            end else begin
               state_nxt.failed = 1'b1;
            end
         end else if (is_digit) begin
            if ((state_cur.digit_count == 3'd0 && word.character == CHAR_ZERO)
                || state_cur.digit_count >= PORT_DIGITS) begin
               state_nxt.failed = 1'b1;
            end else begin
               state_nxt.port_value  = port_acc;
               state_nxt.digit_count = state_cur.digit_count + 3'd1;
            end
         end else begin
            state_nxt.failed = 1'b1;
         end
      end
   end

endmodule

@@ rtl/ipv4_endpoint_text_parser.sv @@
// Top level of the IPv4 endpoint text parser: input register, parser state,
// result register. Depends on ipv4ep_pkg and ipv4ep_step.
//
//   channel | direction | word type      | accepted when
//   req     | in        | req_word_type  | req_valid && req_ready
//   rsp     | out       | rsp_word_type  | rsp_valid && rsp_ready
//
// One word per cycle is taken unless an end word is stalled; an end word's
// verdict is registered in the result register as it leaves the input register.
// The parser state is updated by one pass of ipv4ep_step per word.
// Reset empties both registers and clears the parser state.
// A held result stalls an end word in the input register, and the input with it;
// character words keep flowing while no end word is waiting.
module ipv4_endpoint_text_parser import ipv4ep_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic            in_valid_ff;
   req_word_type    in_word_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_word_type    result;
   logic            rsp_valid_ff;
   rsp_word_type    rsp_word_ff;
   logic            rsp_free;
   logic            advance;
   logic            emit;

   ipv4ep_step u_step (
      .word      (in_word_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (in_word_ff.kind == KIND_CHAR || rsp_free);
   assign emit      = advance && in_word_ff.kind == KIND_END;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
      if (emit) begin
         rsp_word_ff <= result;
      end
   end

`ifndef ASSERT_OFF
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.octet_index <= OCTET_COUNT)
      else $error("octet index beyond four");

   a_port_after_octets: assert property (@(posedge clock) disable iff (reset)
      state_ff.in_port_phase |-> state_ff.octet_index == OCTET_COUNT)
      else $error("port phase entered without four octets");

   a_octet_digits: assert property (@(posedge clock) disable iff (reset)
      !state_ff.in_port_phase |-> state_ff.digit_count <= OCTET_DIGITS)
      else $error("too many octet digits held");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      emit |=> !state_ff.in_port_phase && !state_ff.failed && state_ff.octet_index == 3'd0)
      else $error("state not cleared after end word");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> rsp_free)
      else $error("result overwritten while held");
`endif

endmodule

@@ test/tb_top.sv @@
// Testbench for ipv4_endpoint_text_parser: text words are fed in, and each verdict is
// checked against an in-bench parser that tracks the same state per character.
// Depends on ipv4ep_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_top;
   import ipv4ep_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int IDLE_PERCENT   = 13;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int OCTET_LIMIT    = 255;
   localparam int PORT_LIMIT     = 65535;

   typedef logic [7:0] text_type[$];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   bit           gaps_on = 1'b1;
   int           words_sent = 0;
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   rsp_word_type expected_endpoints[$];

   logic        model_port_phase;
   logic        model_failed;
   logic [2:0]  model_octet_index;
   logic [2:0]  model_digit_count;
   logic [9:0]  model_octet_value;
   logic [7:0]  model_octets[4];
   logic [16:0] model_port_value;

   ipv4_endpoint_text_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void clear_model();
      model_port_phase  = 1'b0;
      model_failed      = 1'b0;
      model_octet_index = '0;
      model_digit_count = '0;
      model_octet_value = '0;
      foreach (model_octets[i]) model_octets[i] = '0;
      model_port_value  = '0;
   endfunction

   function automatic bit close_current_octet();
      if (model_digit_count == 0 || model_octet_value > OCTET_LIMIT) return 1'b0;
      model_octets[model_octet_index[1:0]] = model_octet_value[7:0];
      model_octet_index = model_octet_index + 3'd1;
      model_digit_count = '0;
      model_octet_value = '0;
      return 1'b1;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      bit is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (model_failed) return;
      if (c == CHAR_COLON) begin
         if (model_port_phase || model_octet_index != LAST_OCTET || !close_current_octet()) begin
            model_failed = 1'b1;
         end else begin
            model_port_phase  = 1'b1;
            model_digit_count = '0;
         end
      end else if (!model_port_phase) begin
         if (c == CHAR_DOT) begin
            if (model_octet_index >= LAST_OCTET || !close_current_octet()) model_failed = 1'b1;
         end else if (is_digit && model_digit_count < OCTET_DIGITS) begin
            model_octet_value = 10'(model_octet_value * 10 + (c - CHAR_ZERO));
            model_digit_count = model_digit_count + 3'd1;
         end else begin
            model_failed = 1'b1;
         end
      end else if (is_digit) begin
         if ((model_digit_count == 0 && c == CHAR_ZERO) || model_digit_count >= PORT_DIGITS) begin
            model_failed = 1'b1;
         end else begin
            model_port_value  = 17'(model_port_value * 10 + (c - CHAR_ZERO));
            model_digit_count = model_digit_count + 3'd1;
         end
      end else begin
         model_failed = 1'b1;
      end
   endfunction

   function automatic rsp_word_type close_endpoint();
      rsp_word_type verdict;
      verdict = '0;
      verdict.ok = !model_failed && model_port_phase && model_port_value <= PORT_LIMIT;
      if (verdict.ok) begin
         verdict.octet_0     = model_octets[0];
         verdict.octet_1     = model_octets[1];
         verdict.octet_2     = model_octets[2];
         verdict.octet_3     = model_octets[3];
         verdict.port_number = model_port_value[15:0];
      end
      clear_model();
      return verdict;
   endfunction

   function automatic text_type decimal_text(input int unsigned value, input int unsigned width);
      text_type digits;
      do begin
         digits.push_front(8'(CHAR_ZERO + value % 10));
         value = value / 10;
      end while (value != 0);
      while (digits.size() < width) digits.push_front(CHAR_ZERO);
      return digits;
   endfunction

   function automatic text_type text_of(input string s);
      text_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      return text;
   endfunction

   function automatic text_type make_endpoint();
      text_type    text;
      int unsigned value;
      int unsigned pick;
      for (int i = 0; i < 4; i++) begin
         value = ($urandom_range(9) == 0) ? $urandom_range(999, 256) : $urandom_range(255);
         text = {text, decimal_text(value, $urandom_range(3, 1))};
         if (i < 3) text.push_back(CHAR_DOT);
      end
      if ($urandom_range(19) != 0) text.push_back(CHAR_COLON);
      pick = $urandom_range(99);
      if (pick < 12) begin
      end else if (pick < 20) begin
         text = {text, decimal_text($urandom_range(99999, 65536), 1)};
      end else if (pick < 25) begin
         text = {text, decimal_text($urandom_range(9999), 2)};
      end else if (pick < 60) begin
         text = {text, decimal_text($urandom_range(999, 1), 1)};
      end else begin
         text = {text, decimal_text($urandom_range(65535, 1), 1)};
      end
      return text;
   endfunction

   function automatic text_type damage(input text_type text);
      int unsigned pos;
      pos = (text.size() == 0) ? 0 : $urandom_range(text.size() - 1);
      case ($urandom_range(3))
         0: begin
            if (text.size() != 0) text[pos] = 8'($urandom_range(255));
         end
         1: begin
            if (text.size() != 0) text.delete(pos);
         end
         2: begin
            text.insert(pos, 8'($urandom_range(255)));
         end
         default: begin
            text.insert(pos, ($urandom_range(1) == 0) ? CHAR_DOT : CHAR_COLON);
         end
      endcase
      return text;
   endfunction

   task automatic send_word(input logic kind, input logic [7:0] character);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         req_word  <= {1'($urandom_range(1)), 8'($urandom_range(255))};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= {kind, character};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (kind == KIND_CHAR) parse_char(character);
      else expected_endpoints.push_back(close_endpoint());
   endtask

   task automatic send_endpoint(input text_type text);
      foreach (text[i]) send_word(KIND_CHAR, text[i]);
      send_word(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_endpoints.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed_strings();
      text_type text;
      send_endpoint(text_of("255.255.255.255:65535"));
      send_endpoint(text_of("0.0.0.0:"));
      send_endpoint(text_of("010.001.000.09:1"));
      send_endpoint(text_of(""));
      send_endpoint(text_of("1.2.3.4"));
      send_endpoint(text_of("256.1.1.1:80"));
      send_endpoint(text_of("1.1.1.999:80"));
      send_endpoint(text_of("1..1.1:80"));
      send_endpoint(text_of("1234.1.1.1:1"));
      send_endpoint(text_of("1.2.3.4.5:1"));
      send_endpoint(text_of("1.2.3:1"));
      send_endpoint(text_of("1.2.3.4:1:2"));
      send_endpoint(text_of("1.2.3.4:080"));
      send_endpoint(text_of("1.2.3.4:123456"));
      send_endpoint(text_of("1.2.3.4:65536"));
      send_endpoint(text_of("1.2.3.4:99999"));
      send_endpoint(text_of("1.2.a.4:1"));
      send_endpoint(text_of(":1"));
      text = text_of("1.2.3.4:8");
      text.push_back(8'h00);
      send_endpoint(text);
      text = text_of("9.8.7.6:5");
      text.push_back(8'hFF);
      send_endpoint(text);
      wait_for_results();
   endtask

   task automatic test_random_endpoints();
      text_type text;
      int       target;
      target = words_sent + 750;
      while (words_sent < target) begin
         text = make_endpoint();
         if ($urandom_range(3) == 0) text = damage(text);
         send_endpoint(text);
         if ($urandom_range(19) == 0) wait_for_results();
      end
   endtask

   task automatic test_steady_stream();
      int target;
      target = words_sent + 250;
      gaps_on = 1'b0;
      while (words_sent < target) send_endpoint(make_endpoint());
      gaps_on = 1'b1;
   endtask

   task automatic test_noise_strings();
      text_type text;
      int       target;
      target = words_sent + 200;
      while (words_sent < target) begin
         text.delete();
         repeat ($urandom_range(12)) begin
            case ($urandom_range(3))
               0:       text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
               1:       text.push_back(CHAR_DOT);
               2:       text.push_back(CHAR_COLON);
               default: text.push_back(8'($urandom_range(255)));
            endcase
         end
         send_endpoint(text);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_endpoints.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %p", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = expected_endpoints.pop_front();
            check_field("ok", 16'(want.ok), 16'(rsp_word.ok));
            check_field("octet_0", 16'(want.octet_0), 16'(rsp_word.octet_0));
            check_field("octet_1", 16'(want.octet_1), 16'(rsp_word.octet_1));
            check_field("octet_2", 16'(want.octet_2), 16'(rsp_word.octet_2));
            check_field("octet_3", 16'(want.octet_3), 16'(rsp_word.octet_3));
            check_field("port_number", want.port_number, rsp_word.port_number);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_random_endpoints();
      test_steady_stream();
      test_noise_strings();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_endpoints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ipv4ep_pkg.sv
rtl/ipv4ep_step.sv
rtl/ipv4_endpoint_text_parser.sv
test/tb_top.sv
